@@ rtl/ordered_list_engine_unit_macros.svh @@
// Assertion macros shared by the checker of the ordered list engine.
// No dependencies; include by bare file name.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ole_pkg.sv @@
// Types and codes for the ordered list engine.
// No dependencies; used by ordered_list_engine_unit and ole_checker.
package ole_pkg;

   typedef enum logic [2:0] {
      ACT_APPEND     = 3'd0,
      ACT_INSERT_AT  = 3'd1,
      ACT_DEL_FIRST  = 3'd2,
      ACT_DEL_LAST   = 3'd3,
      ACT_DEL_AT     = 3'd4,
      ACT_SEARCH     = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_FULL      = 3'd1,
      STS_EMPTY     = 3'd2,
      STS_BAD_POS   = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OLE_IDLE,
      OLE_SHIFT_UP,
      OLE_SHIFT_DOWN,
      OLE_SEARCH
   } state_type;

endpackage

@@ rtl/ordered_list_engine_unit.sv @@
// Ordered list engine: list of signed words held in one single-port-write RAM.
// Depends on ole_pkg.
//
// Usage: raise start with req_action/req_value/req_position while busy is low;
// the transaction is taken at that edge. Exactly one result appears for one
// cycle with rsp_strobe high; it cannot be held off, so capture it then.
// Rejected requests (full, empty, bad position, unused action codes) answer on
// the next cycle without raising busy. Otherwise busy stays high while the
// list RAM is walked one entry per cycle, with the reads pipelined with the
// write-back: an insert moves every entry from its position to the end one
// slot higher, a delete moves every entry behind the deleted entry one slot
// lower, and a search reads from the head until the first match or the end
// of the list; append, insert at the end and delete last walk no entries.
// The result strobes on the cycle busy falls. The list is empty after reset;
// no clearing pass is needed.
module ordered_list_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_found_index,
   output logic [6:0]         rsp_item_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 7) ? CW : 7;

   ole_pkg::state_type state_ff, state_in;

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      waddr_ff, waddr_in;
   logic               pend_ff, pend_in;
   logic signed [31:0] value_ff, value_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [AW-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [CW-1:0]      rsp_cnt_ff, rsp_cnt_in;

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rd_data_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic signed [31:0] mem_wdata;

   logic               accept, full, empty;
   logic               up_done, down_done, hit, miss;
   logic [XW-1:0]      pos_x, cnt_x;

   assign accept = start && (state_ff == ole_pkg::OLE_IDLE);
   assign busy   = (state_ff != ole_pkg::OLE_IDLE);
   assign full   = (cnt_ff == CW'(CAPACITY));
   assign empty  = (cnt_ff == '0);
   assign pos_x  = XW'(req_position);
   assign cnt_x  = XW'(cnt_ff);

   assign up_done   = (state_ff == ole_pkg::OLE_SHIFT_UP) && !pend_ff && (ptr_ff == pos_ff);
   assign down_done = (state_ff == ole_pkg::OLE_SHIFT_DOWN) && !pend_ff && (ptr_ff == cnt_ff);
   assign hit       = (state_ff == ole_pkg::OLE_SEARCH) && pend_ff && (rd_data_ff == value_ff);
   assign miss      = (state_ff == ole_pkg::OLE_SEARCH) && !pend_ff && (ptr_ff == cnt_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ole_pkg::OLE_IDLE: begin
            if (accept) begin
               case (ole_pkg::action_type'(req_action)) inside
                  ole_pkg::ACT_APPEND: begin
                     if (!full) state_in = ole_pkg::OLE_SHIFT_UP;
                  end
                  ole_pkg::ACT_INSERT_AT: begin
                     if (!full && (pos_x <= cnt_x)) state_in = ole_pkg::OLE_SHIFT_UP;
                  end
                  ole_pkg::ACT_DEL_FIRST, ole_pkg::ACT_DEL_LAST: begin
                     if (!empty) state_in = ole_pkg::OLE_SHIFT_DOWN;
                  end
                  ole_pkg::ACT_DEL_AT: begin
                     if (!empty && (pos_x < cnt_x)) state_in = ole_pkg::OLE_SHIFT_DOWN;
                  end
                  ole_pkg::ACT_SEARCH: begin
                     if (!empty) state_in = ole_pkg::OLE_SEARCH;
                  end
                  default: state_in = ole_pkg::OLE_IDLE;
               endcase
            end
         end
         ole_pkg::OLE_SHIFT_UP: begin
            if (up_done) state_in = ole_pkg::OLE_IDLE;
         end
         ole_pkg::OLE_SHIFT_DOWN: begin
            if (down_done) state_in = ole_pkg::OLE_IDLE;
         end
         ole_pkg::OLE_SEARCH: begin
            if (hit || miss) state_in = ole_pkg::OLE_IDLE;
         end
         default: state_in = ole_pkg::OLE_IDLE;
      endcase
   end

   // Datapath, memory access and result
   always_comb begin
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      waddr_in      = waddr_ff;
      pend_in       = 1'b0;
      value_in      = value_ff;
      mem_we        = 1'b0;
      mem_waddr     = waddr_ff;
      mem_wdata     = rd_data_ff;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff[AW-1:0];
      rsp_strobe_in = 1'b0;
      rsp_status_in = ole_pkg::STS_OK;
      rsp_idx_in    = '0;
      rsp_cnt_in    = cnt_ff;
      unique case (state_ff)
         ole_pkg::OLE_IDLE: begin
            if (accept) begin
               value_in = req_value;
               case (ole_pkg::action_type'(req_action))
                  ole_pkg::ACT_APPEND: begin
                     if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_FULL;
                     end else begin
                        ptr_in = cnt_ff;
                        pos_in = cnt_ff;
                     end
                  end
                  ole_pkg::ACT_INSERT_AT: begin
                     if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_FULL;
                     end else if (pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_BAD_POS;
                     end else begin
                        ptr_in = cnt_ff;
                        pos_in = CW'(pos_x);
                     end
                  end
                  ole_pkg::ACT_DEL_FIRST: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_EMPTY;
                     end else begin
                        ptr_in = CW'(1);
                     end
                  end
                  ole_pkg::ACT_DEL_LAST: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_EMPTY;
                     end else begin
                        ptr_in = cnt_ff;
                     end
                  end
                  ole_pkg::ACT_DEL_AT: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_BAD_POS;
                     end else begin
                        ptr_in = CW'(pos_x) + CW'(1);
                     end
                  end
                  ole_pkg::ACT_SEARCH: begin
                     if (empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ole_pkg::STS_EMPTY;
                     end else begin
                        ptr_in = '0;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ole_pkg::OLE_SHIFT_UP: begin
            // write back the entry read last cycle one slot higher
            if (pend_ff) begin
               mem_we = 1'b1;
            end else if (ptr_ff == pos_ff) begin
               mem_we        = 1'b1;
               mem_waddr     = pos_ff[AW-1:0];
               mem_wdata     = value_ff;
               cnt_in        = cnt_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_cnt_in    = cnt_ff + CW'(1);
            end
            if (ptr_ff > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_ff - CW'(1));
               waddr_in  = ptr_ff[AW-1:0];
               ptr_in    = ptr_ff - CW'(1);
               pend_in   = 1'b1;
            end
         end
         ole_pkg::OLE_SHIFT_DOWN: begin
            // write back the entry read last cycle one slot lower
            if (pend_ff) begin
               mem_we = 1'b1;
            end else if (ptr_ff == cnt_ff) begin
               cnt_in        = cnt_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_cnt_in    = cnt_ff - CW'(1);
            end
            if (ptr_ff < cnt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff[AW-1:0];
               waddr_in  = AW'(ptr_ff - CW'(1));
               ptr_in    = ptr_ff + CW'(1);
               pend_in   = 1'b1;
            end
         end
         ole_pkg::OLE_SEARCH: begin
            if (hit) begin
               rsp_strobe_in = 1'b1;
               rsp_idx_in    = waddr_ff;
            end else begin
               if (miss) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ole_pkg::STS_NOT_FOUND;
               end
               if (ptr_ff < cnt_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = ptr_ff[AW-1:0];
                  waddr_in  = ptr_ff[AW-1:0];
                  ptr_in    = ptr_ff + CW'(1);
                  pend_in   = 1'b1;
               end
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ole_pkg::OLE_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      waddr_ff      <= waddr_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = 6'(rsp_idx_ff);
   assign rsp_item_count  = 7'(rsp_cnt_ff);

endmodule

@@ rtl/ole_checker.sv @@
// Port-level checks for ordered_list_engine_unit, attached by bind.
// Depends on ole_pkg and ordered_list_engine_unit_macros.svh.
`include "ordered_list_engine_unit_macros.svh"

module ole_checker #(
   parameter int CAPACITY = 64
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [2:0]         rsp_status,
   input logic [5:0]         rsp_found_index,
   input logic [6:0]         rsp_item_count
);

   logic taken;
   logic full_rsp;
   logic empty_rsp;
   logic fail_rsp;
   logic count_full;
   logic count_zero;
   logic index_zero;

   assign taken      = start && !busy;
   assign full_rsp   = rsp_strobe && (rsp_status == ole_pkg::STS_FULL);
   assign empty_rsp  = rsp_strobe && (rsp_status == ole_pkg::STS_EMPTY);
   assign fail_rsp   = rsp_strobe && (rsp_status != ole_pkg::STS_OK);
   assign count_full = (rsp_item_count == 7'(CAPACITY));
   assign count_zero = (rsp_item_count == 7'd0);
   assign index_zero = (rsp_found_index == 6'd0);

   // an accepted transaction either answers at once or keeps the engine busy
   `OLE_ASSERT_NEXT(a_take_answers, clock, reset, taken, busy || rsp_strobe, "accept unanswered")
   `OLE_ASSERT_NOW(a_done_strobes, clock, reset, $fell(busy), rsp_strobe, "no result at end")
   `OLE_ASSERT_NOW(a_full_count, clock, reset, full_rsp, count_full, "wrong count on full")
   `OLE_ASSERT_NOW(a_empty_count, clock, reset, empty_rsp, count_zero, "wrong count on empty")
   `OLE_ASSERT_NOW(a_fail_index, clock, reset, fail_rsp, index_zero, "index on failed request")

endmodule

bind ordered_list_engine_unit ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

@@ tb/sv/tb_ordered_list_engine_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_engine_unit: list actions go in through start/busy,
// every response is checked against a list mirror kept inside the bench.
// Depends on ole_pkg and the ordered_list_engine_unit RTL.
module tb_ordered_list_engine_unit;

   localparam int CAPACITY       = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = CAPACITY + 8;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mode_type;

   typedef struct packed {
      ole_pkg::status_type status;
      logic [5:0]          found_index;
      logic [6:0]          item_count;
   } list_rsp_type;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               start        = 1'b0;
   logic [2:0]         req_action   = '0;
   logic signed [31:0] req_value    = '0;
   logic [6:0]         req_position = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic [5:0]         rsp_found_index;
   logic [6:0]         rsp_item_count;

   logic signed [31:0] list_mirror[$];
   list_rsp_type       pending_rsp_q[$];
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   bit                 gaps_on = 1'b1;

   ordered_list_engine_unit #(.CAPACITY(CAPACITY)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_item_count  (rsp_item_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   // Apply one action to the mirror and return the response it must produce.
   function automatic list_rsp_type predict_list_op(logic [2:0] action,
                                                    logic signed [31:0] value,
                                                    logic [6:0] position);
      list_rsp_type rsp;
      int           count;
      count           = list_mirror.size();
      rsp.status      = ole_pkg::STS_OK;
      rsp.found_index = '0;
      case (action)
         ole_pkg::ACT_APPEND: begin
            if (count >= CAPACITY) rsp.status = ole_pkg::STS_FULL;
            else list_mirror.push_back(value);
         end
         ole_pkg::ACT_INSERT_AT: begin
            if (count >= CAPACITY) rsp.status = ole_pkg::STS_FULL;
            else if (int'(position) > count) rsp.status = ole_pkg::STS_BAD_POS;
            else list_mirror.insert(int'(position), value);
         end
         ole_pkg::ACT_DEL_FIRST: begin
            if (count == 0) rsp.status = ole_pkg::STS_EMPTY;
            else void'(list_mirror.pop_front());
         end
         ole_pkg::ACT_DEL_LAST: begin
            if (count == 0) rsp.status = ole_pkg::STS_EMPTY;
            else void'(list_mirror.pop_back());
         end
         ole_pkg::ACT_DEL_AT: begin
            if (count == 0) rsp.status = ole_pkg::STS_EMPTY;
            else if (int'(position) >= count) rsp.status = ole_pkg::STS_BAD_POS;
            else list_mirror.delete(int'(position));
         end
         ole_pkg::ACT_SEARCH: begin
            if (count == 0) begin
               rsp.status = ole_pkg::STS_EMPTY;
            end else begin
               rsp.status = ole_pkg::STS_NOT_FOUND;
               for (int i = 0; i < count; i++) begin
                  if (list_mirror[i] == value) begin
                     rsp.status      = ole_pkg::STS_OK;
                     rsp.found_index = i[5:0];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      rsp.item_count = 7'(list_mirror.size());
      return rsp;
   endfunction

   // Called at a rising edge; returns at the taking edge, start high, or after a random gap, start low.
   task automatic send_request(logic [2:0] action, logic signed [31:0] value,
                               logic [6:0] position);
      req_action   <= action;
      req_value    <= value;
      req_position <= position;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp_q.push_back(predict_list_op(action, value, position));
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         // small values breed duplicates, so search must return the first match
         0: return $urandom_range(0, 7);
         1: begin
            if (list_mirror.size() != 0)
               return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
            return $urandom;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_item(traffic_mode_type mode);
      int         roll;
      int         w_append;
      int         w_insert;
      int         w_search;
      logic [2:0] action;
      logic [6:0] position;
      roll = $urandom_range(0, 99);
      case (mode)
         MIX_GROW:   begin w_append = 40; w_insert = 35; w_search = 10; end
         MIX_SHRINK: begin w_append = 8;  w_insert = 8;  w_search = 14; end
         default:    begin w_append = 18; w_insert = 18; w_search = 28; end
      endcase
      if (roll < 3)
         action = roll[0] ? ACT_SPARE_7 : ACT_SPARE_6;
      else if (roll < w_append)
         action = ole_pkg::ACT_APPEND;
      else if (roll < w_append + w_insert)
         action = ole_pkg::ACT_INSERT_AT;
      else if (roll < w_append + w_insert + w_search)
         action = ole_pkg::ACT_SEARCH;
      else
         case ($urandom_range(0, 2))
            0:       action = ole_pkg::ACT_DEL_FIRST;
            1:       action = ole_pkg::ACT_DEL_LAST;
            default: action = ole_pkg::ACT_DEL_AT;
         endcase
      if ($urandom_range(0, 9) == 0)
         position = 7'($urandom_range(0, 127));
      else
         position = 7'($urandom_range(0, list_mirror.size()));
      send_request(action, pick_value(), position);
   endtask

   task automatic test_empty_list();
      send_request(ole_pkg::ACT_SEARCH, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_DEL_FIRST, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_DEL_LAST, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_INSERT_AT, 32'sd9, 7'd1);
      send_request(ACT_SPARE_6, 32'sd0, 7'd0);
      send_request(ACT_SPARE_7, -32'sd1, 7'd127);
   endtask

   task automatic test_edge_values();
      send_request(ole_pkg::ACT_INSERT_AT, 32'sh8000_0000, 7'd0);
      send_request(ole_pkg::ACT_APPEND, 32'sh7fff_ffff, 7'd0);
      send_request(ole_pkg::ACT_APPEND, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_APPEND, -32'sd1, 7'd0);
      send_request(ole_pkg::ACT_SEARCH, -32'sd1, 7'd0);
      send_request(ole_pkg::ACT_SEARCH, 32'sd12345, 7'd0);
      send_request(ole_pkg::ACT_SEARCH, 32'sh8000_0000, 7'd0);
      // insert at the current count behaves as append
      send_request(ole_pkg::ACT_INSERT_AT, 32'sd1, 7'd4);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd5);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd127);
      send_request(ole_pkg::ACT_INSERT_AT, 32'sd2, 7'd127);
      // delete just behind the head, then the head itself
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd1);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_DEL_FIRST, 32'sd0, 7'd0);
      send_request(ole_pkg::ACT_DEL_LAST, 32'sd0, 7'd0);
   endtask

   task automatic test_fill_to_capacity();
      while (list_mirror.size() < CAPACITY)
         send_request(ole_pkg::ACT_APPEND, pick_value(), 7'($urandom_range(0, 127)));
      send_request(ole_pkg::ACT_APPEND, 32'sd5, 7'd0);
      send_request(ole_pkg::ACT_INSERT_AT, 32'sd5, 7'd0);
      send_request(ole_pkg::ACT_INSERT_AT, 32'sd5, 7'd64);
      send_request(ole_pkg::ACT_SEARCH, list_mirror[CAPACITY - 1], 7'd0);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd63);
      send_request(ole_pkg::ACT_INSERT_AT, 32'sh7fff_ffff, 7'd63);
      send_request(ole_pkg::ACT_DEL_AT, 32'sd0, 7'd64);
   endtask

   task automatic test_random_traffic(int n_items, bit allow_gaps);
      traffic_mode_type mode;
      int               left_in_mode;
      left_in_mode = 0;
      mode         = MIX_BALANCED;
      for (int n = 0; n < n_items; n++) begin
         if (left_in_mode == 0) begin
            if (allow_gaps && $urandom_range(0, 7) == 0) wait_for_drain();
            mode         = traffic_mode_type'($urandom_range(0, 2));
            left_in_mode = $urandom_range(40, 120);
            gaps_on      = allow_gaps && ($urandom_range(0, 3) != 0);
         end
         send_random_item(mode);
         left_in_mode--;
      end
   endtask

   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response with none pending, status %0d", rsp_status));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_status, want.status));
            if (rsp_found_index !== want.found_index)
               report_mismatch($sformatf("found_index got %0d expected %0d",
                                         rsp_found_index, want.found_index));
            if (rsp_item_count !== want.item_count)
               report_mismatch($sformatf("item_count got %0d expected %0d",
                                         rsp_item_count, want.item_count));
         end
      end
   end

   // End the run when no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_ordered_list_engine_unit: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_edge_values();
      wait_for_drain();
      test_fill_to_capacity();
      wait_for_drain();
      test_random_traffic(1330, 1'b1);
      wait_for_drain();
      test_random_traffic(120, 1'b0);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_rsp_q.size()));
      if (error_count == 0) begin
         $display("tb_ordered_list_engine_unit: done, clean");
      end else begin
         $display("tb_ordered_list_engine_unit: done, errors");
      end
      $finish;
   end

endmodule
